@@ rtl/core/tcc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types, widths and helpers for the timer/counter with compare outputs.
// ----------------------------------------------------------------------------
package tcc_pkg;

   // counter width, 8 to 16
   localparam int COUNT_WIDTH = 16;

   // port widths
   localparam int REQ_USER_W  = 2;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_COUNT_W = 16;
   localparam int RSP_DATA_W  = 24;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int FLAG_W      = 3;

   // flag bit positions
   localparam int FLAG_OVF = 0;
   localparam int FLAG_A   = 1;
   localparam int FLAG_B   = 2;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   // item commands
   typedef enum logic [REQ_USER_W-1:0] {
      CMD_TICK    = 2'd0,
      CMD_CLEAR   = 2'd1,
      CMD_RESTART = 2'd2
   } cmd_type;

   // compare pin actions
   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_TOGGLE = 2'd1,
      ACT_CLEAR  = 2'd2,
      ACT_SET    = 2'd3
   } action_type;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CTC_MODE     = 3'd0,
      CSR_CLOCK_ENABLE = 3'd1,
      CSR_COMPARE_A    = 3'd2,
      CSR_COMPARE_B    = 3'd3,
      CSR_PIN_A_ACTION = 3'd4,
      CSR_PIN_B_ACTION = 3'd5,
      CSR_IRQ_ENABLE   = 3'd6
   } csr_index_type;

   // pin level after a match
   function automatic logic apply_action(input logic level, input action_type action);
      logic result;
      unique case (action)
         ACT_TOGGLE: result = ~level;
         ACT_CLEAR:  result = 1'b0;
         ACT_SET:    result = 1'b1;
         default:    result = level;
      endcase
      return result;
   endfunction

endpackage

@@ rtl/core/timer_counter_normal_ctc_compare.sv @@
`timescale 1ns / 1ps
// a result is registered in the result register, or in the skid while the output stalls
// throughput: one item per cycle while the skid is empty; the counter, flags and
//   pins update in the accept cycle, so the next item sees them at once
// a two-deep output stage (result register plus skid) keeps input open until the skid fills
// reset: synchronous, clears counter, flags, pins, registers and both output beats
// ----------------------------------------------------------------------------
// timer_counter_normal_ctc_compare
// Timer/counter with normal and clear-on-compare modes, two compare channels
// with pin actions, write-one-to-clear flags and a masked interrupt output.
// ----------------------------------------------------------------------------
module timer_counter_normal_ctc_compare import tcc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [2:0] flag_mask, [7:3] zero
   input  logic [REQ_USER_W-1:0]  req_tuser,   // [1:0] cmd
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [15:0] count_value, [16] overflow_flag,
                                               // [17] match_a_flag, [18] match_b_flag,
                                               // [19] irq, [20] pin_a, [21] pin_b, [23:22] zero
   // configuration writes
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // configuration registers
   logic                   ctc_mode_ff;
   logic                   clock_enable_ff;
   logic [CSR_DATA_W-1:0]  compare_a_ff;
   logic [CSR_DATA_W-1:0]  compare_b_ff;
   action_type             pin_a_action_ff;
   action_type             pin_b_action_ff;
   logic [FLAG_W-1:0]      irq_enable_ff;

   // timer state
   count_type              counter_ff, counter_in;
   logic [FLAG_W-1:0]      flag_bits_ff, flag_bits_in;
   logic                   pin_a_ff, pin_a_in;
   logic                   pin_b_ff, pin_b_in;

   // output stage
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                   skid_valid_ff, skid_valid_in;
   logic [RSP_DATA_W-1:0]  skid_data_ff, skid_data_in;

   // datapath
   logic                   accept;
   logic                   out_load;
   count_type              top;
   count_type              cmp_b;
   count_type              count_step;
   logic                   wrap_ovf;
   logic                   irq_new;
   logic [RSP_DATA_W-1:0]  result;

   assign accept     = req_tvalid & req_tready;
   assign req_tready = ~skid_valid_ff;
   assign out_load   = ~rsp_valid_ff | rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign top   = compare_a_ff[COUNT_WIDTH-1:0];
   assign cmp_b = compare_b_ff[COUNT_WIDTH-1:0];

   // configuration register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ctc_mode_ff     <= 1'b0;
         clock_enable_ff <= 1'b0;
         compare_a_ff    <= '0;
         compare_b_ff    <= '0;
         pin_a_action_ff <= ACT_NONE;
         pin_b_action_ff <= ACT_NONE;
         irq_enable_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CTC_MODE:     ctc_mode_ff     <= csr_wdata[0];
            CSR_CLOCK_ENABLE: clock_enable_ff <= csr_wdata[0];
            CSR_COMPARE_A:    compare_a_ff    <= csr_wdata;
            CSR_COMPARE_B:    compare_b_ff    <= csr_wdata;
            CSR_PIN_A_ACTION: pin_a_action_ff <= action_type'(csr_wdata[1:0]);
            CSR_PIN_B_ACTION: pin_b_action_ff <= action_type'(csr_wdata[1:0]);
            CSR_IRQ_ENABLE:   irq_enable_ff   <= csr_wdata[FLAG_W-1:0];
            default: ;
         endcase
      end
   end

   // count step for a tick: clear at top in ctc mode, wrap at maximum
   always_comb begin
      wrap_ovf = 1'b0;
      priority if (ctc_mode_ff && counter_ff == top) begin
         count_step = '0;
      end else if (counter_ff == {COUNT_WIDTH{1'b1}}) begin
         count_step = '0;
         wrap_ovf   = ~ctc_mode_ff;
      end else begin
         count_step = counter_ff + count_type'(1);
      end
   end

   // next timer state for the accepted item
   always_comb begin
      counter_in   = counter_ff;
      flag_bits_in = flag_bits_ff;
      pin_a_in     = pin_a_ff;
      pin_b_in     = pin_b_ff;
      if (accept) begin
         unique case (cmd_type'(req_tuser))
            CMD_TICK: begin
               if (clock_enable_ff) begin
                  counter_in = count_step;
                  if (wrap_ovf) flag_bits_in[FLAG_OVF] = 1'b1;
                  if (count_step == top) begin
                     flag_bits_in[FLAG_A] = 1'b1;
                     pin_a_in = apply_action(pin_a_ff, pin_a_action_ff);
                  end
                  if (count_step == cmp_b) begin
                     flag_bits_in[FLAG_B] = 1'b1;
                     pin_b_in = apply_action(pin_b_ff, pin_b_action_ff);
                  end
               end
            end
            CMD_CLEAR:   flag_bits_in = flag_bits_ff & ~req_tdata[FLAG_W-1:0];
            CMD_RESTART: counter_in   = '0;
            default: ;
         endcase
      end
   end

   // result beat packing
   assign irq_new = |(flag_bits_in & irq_enable_ff);
   assign result  = {2'b00, pin_b_in, pin_a_in, irq_new,
                     flag_bits_in[FLAG_B], flag_bits_in[FLAG_A], flag_bits_in[FLAG_OVF],
                     RSP_COUNT_W'(counter_in)};

   // result register with skid beat behind it
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_load) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = accept;
            rsp_data_in  = result;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   // state and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff    <= '0;
         flag_bits_ff  <= '0;
         pin_a_ff      <= 1'b0;
         pin_b_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         counter_ff    <= counter_in;
         flag_bits_ff  <= flag_bits_in;
         pin_a_ff      <= pin_a_in;
         pin_b_ff      <= pin_b_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

@@ rtl/core/tcc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_checker
// Port-level checks for the timer/counter, bound to the top level.
// ----------------------------------------------------------------------------
module tcc_checker import tcc_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_DATA_W-1:0]  req_tdata,
   input logic [REQ_USER_W-1:0]  req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_DATA_W-1:0]  rsp_tdata
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // reset leaves no result pending and input open
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("output stage not empty after reset");

   // input closes only when a result is waiting
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result pending");

   // restart with a free output shows a zero count next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == CMD_RESTART && (!rsp_tvalid || rsp_tready)
      |=> rsp_tvalid && rsp_tdata[15:0] == 16'd0)
      else $error("restart did not clear count");

   // clearing all flags drops flags and irq
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == CMD_CLEAR && req_tdata[2:0] == 3'b111
      && (!rsp_tvalid || rsp_tready)
      |=> rsp_tvalid && rsp_tdata[19:16] == 4'd0)
      else $error("flag clear left flags or irq set");

endmodule

bind timer_counter_normal_ctc_compare tcc_checker u_tcc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the timer/counter with compare outputs. A directed
// table covers reset, the stopped clock, pin actions, flag clearing, restart
// and clear-on-compare, then random phases of settings and beats follow.
// Every result beat is checked field by field against an in-bench timer model or a table value.
// ----------------------------------------------------------------------------
module tb;
   import tcc_pkg::*;

   // spare command code, not decoded by the block
   localparam logic [REQ_USER_W-1:0] CMD_SPARE = 2'd3;
   localparam int LATENCY      = 1;
   localparam int RANDOM_ITEMS = 1100;

   // result fields, laid out as in rsp_tdata
   typedef struct packed {
      logic                   pin_b;
      logic                   pin_a;
      logic                   irq;
      logic                   match_b;
      logic                   match_a;
      logic                   overflow;
      logic [RSP_COUNT_W-1:0] count;
   } timer_rsp_type;

   // one directed step: a register write or a beat
   typedef struct packed {
      logic                   is_csr;
      logic [CSR_INDEX_W-1:0] csr_index;
      logic [CSR_DATA_W-1:0]  csr_value;
      logic [REQ_USER_W-1:0]  cmd;
      logic [FLAG_W-1:0]      mask;
      logic                   known;
      timer_rsp_type          want;
   } plan_row_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;   // [2:0] flag_mask, [7:3] zero
   logic [REQ_USER_W-1:0]  req_tuser  = '0;   // [1:0] cmd
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;         // [15:0] count_value, [16] overflow_flag,
                                              // [17] match_a_flag, [18] match_b_flag,
                                              // [19] irq, [20] pin_a, [21] pin_b
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   // shadow settings
   logic                   cfg_ctc_mode     = 1'b0;
   logic                   cfg_clock_enable = 1'b0;
   logic [CSR_DATA_W-1:0]  cfg_compare_a    = '0;
   logic [CSR_DATA_W-1:0]  cfg_compare_b    = '0;
   action_type             cfg_pin_a_action = ACT_NONE;
   action_type             cfg_pin_b_action = ACT_NONE;
   logic [FLAG_W-1:0]      cfg_irq_enable   = '0;

   // shadow timer state
   count_type              tmr_count = '0;
   logic [FLAG_W-1:0]      tmr_flags = '0;
   logic                   tmr_pin_a = 1'b0;
   logic                   tmr_pin_b = 1'b0;

   timer_rsp_type          timer_expected [$];
   plan_row_type           plan [$];
   int unsigned            mismatch_count = 0;
   int unsigned            rsp_wait = 0;
   logic                   gaps_on = 1'b1;

   timer_counter_normal_ctc_compare dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // pin level after a compare match
   function automatic logic pin_after_match(input logic level, input action_type action);
      case (action)
         ACT_TOGGLE: return ~level;
         ACT_CLEAR:  return 1'b0;
         ACT_SET:    return 1'b1;
         default:    return level;
      endcase
   endfunction

   // advance the shadow timer by one beat and return the state it reports
   function automatic timer_rsp_type step_timer(input logic [REQ_USER_W-1:0] cmd,
                                                input logic [FLAG_W-1:0] mask);
      count_type     top;
      count_type     mark_b;
      timer_rsp_type res;
      top    = count_type'(cfg_compare_a);
      mark_b = count_type'(cfg_compare_b);
      case (cmd)
         CMD_TICK: begin
            if (cfg_clock_enable) begin
               if (cfg_ctc_mode && tmr_count == top) begin
                  tmr_count = '0;
               end else if (tmr_count == '1) begin
                  // wrap; overflow only counts in normal mode
                  tmr_count = '0;
                  if (!cfg_ctc_mode) tmr_flags[FLAG_OVF] = 1'b1;
               end else begin
                  tmr_count = tmr_count + 1'b1;
               end
               if (tmr_count == top) begin
                  tmr_flags[FLAG_A] = 1'b1;
                  tmr_pin_a = pin_after_match(tmr_pin_a, cfg_pin_a_action);
               end
               if (tmr_count == mark_b) begin
                  tmr_flags[FLAG_B] = 1'b1;
                  tmr_pin_b = pin_after_match(tmr_pin_b, cfg_pin_b_action);
               end
            end
         end
         CMD_CLEAR:   tmr_flags = tmr_flags & ~mask;
         CMD_RESTART: tmr_count = '0;
         default: ;
      endcase
      res.count    = RSP_COUNT_W'(tmr_count);
      res.overflow = tmr_flags[FLAG_OVF];
      res.match_a  = tmr_flags[FLAG_A];
      res.match_b  = tmr_flags[FLAG_B];
      res.irq      = |(tmr_flags & cfg_irq_enable);
      res.pin_a    = tmr_pin_a;
      res.pin_b    = tmr_pin_b;
      return res;
   endfunction

   // table row builders
   function automatic plan_row_type csr_row(input csr_index_type idx,
                                            input logic [CSR_DATA_W-1:0] value);
      plan_row_type row;
      row           = '0;
      row.is_csr    = 1'b1;
      row.csr_index = idx;
      row.csr_value = value;
      return row;
   endfunction

   function automatic plan_row_type beat_row(input logic [REQ_USER_W-1:0] cmd,
                                             input logic [FLAG_W-1:0] mask);
      plan_row_type row;
      row      = '0;
      row.cmd  = cmd;
      row.mask = mask;
      return row;
   endfunction

   function automatic plan_row_type known_row(input logic [REQ_USER_W-1:0] cmd,
                                              input logic [FLAG_W-1:0] mask,
                                              input timer_rsp_type want);
      plan_row_type row;
      row       = beat_row(cmd, mask);
      row.known = 1'b1;
      row.want  = want;
      return row;
   endfunction

   // register write; the next beat lowers the enable
   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_CTC_MODE:     cfg_ctc_mode     = value[0];
         CSR_CLOCK_ENABLE: cfg_clock_enable = value[0];
         CSR_COMPARE_A:    cfg_compare_a    = value;
         CSR_COMPARE_B:    cfg_compare_b    = value;
         CSR_PIN_A_ACTION: cfg_pin_a_action = action_type'(value[1:0]);
         CSR_PIN_B_ACTION: cfg_pin_b_action = action_type'(value[1:0]);
         CSR_IRQ_ENABLE:   cfg_irq_enable   = value[FLAG_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // request beat with a random lead gap
   task automatic send_beat(input logic [REQ_USER_W-1:0] cmd, input logic [FLAG_W-1:0] mask,
                            input logic known, input timer_rsp_type want);
      int unsigned   gap;
      timer_rsp_type predicted;
      gap = gaps_on ? $urandom_range(0, 4) : 0;
      csr_we <= 1'b0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= REQ_DATA_W'(mask);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = step_timer(cmd, mask);
      timer_expected.push_back(known ? want : predicted);
   endtask

   // wait until the block is idle before touching registers
   task automatic settle();
      req_tvalid <= 1'b0;
      while (timer_expected.size() != 0) @(posedge clock);
      repeat (LATENCY + 1) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [RSP_COUNT_W-1:0] want,
                              input logic [RSP_COUNT_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // result side back-pressure
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready)
         rsp_wait = gaps_on ? $urandom_range(0, 4) : 0;
      else if (rsp_wait != 0)
         rsp_wait = rsp_wait - 1;
      rsp_tready <= (rsp_wait == 0);
   end

   // result beat checker
   always @(posedge clock) begin
      timer_rsp_type got;
      timer_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = timer_rsp_type'(rsp_tdata[$bits(timer_rsp_type)-1:0]);
         if (timer_expected.size() == 0) begin
            $error("result beat with nothing expected: %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = timer_expected.pop_front();
            check_field("count_value",   want.count,    got.count);
            check_field("overflow_flag", want.overflow, got.overflow);
            check_field("match_a_flag",  want.match_a,  got.match_a);
            check_field("match_b_flag",  want.match_b,  got.match_b);
            check_field("irq",           want.irq,      got.irq);
            check_field("pin_a",         want.pin_a,    got.pin_a);
            check_field("pin_b",         want.pin_b,    got.pin_b);
         end
      end
   end

   // run limit
   initial begin
      #(10_000_000);
      $display("[timer_counter_normal_ctc_compare] ERROR");
      $finish;
   end

   // stimulus
   initial begin
      logic                   prev_csr;
      logic [CSR_DATA_W-1:0]  value;
      logic [REQ_USER_W-1:0]  cmd;
      int unsigned            random_items;
      int unsigned            phase_len;
      int unsigned            pick;
      int unsigned            drain;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      plan = '{
         // after reset: stopped clock, spare command, idle clear and restart
         known_row(CMD_TICK,    3'b000, '0),
         known_row(CMD_SPARE,   3'b111, '0),
         known_row(CMD_CLEAR,   3'b111, '0),
         known_row(CMD_RESTART, 3'b000, '0),
         // normal mode, toggle on A and set on B
         csr_row(CSR_CTC_MODE,     16'd0),
         csr_row(CSR_CLOCK_ENABLE, 16'd1),
         csr_row(CSR_COMPARE_A,    16'd2),
         csr_row(CSR_COMPARE_B,    16'd3),
         csr_row(CSR_PIN_A_ACTION, 16'(ACT_TOGGLE)),
         csr_row(CSR_PIN_B_ACTION, 16'(ACT_SET)),
         csr_row(CSR_IRQ_ENABLE,   16'd7),
         beat_row(CMD_TICK,  3'b111),
         beat_row(CMD_TICK,  3'b000),
         beat_row(CMD_TICK,  3'b101),
         beat_row(CMD_CLEAR, 3'b010),
         beat_row(CMD_SPARE, 3'b101),
         beat_row(CMD_TICK,  3'b000),
         // stopped clock holds the count
         csr_row(CSR_CLOCK_ENABLE, 16'd0),
         beat_row(CMD_TICK,  3'b000),
         // clear on compare A, restart does not match B at zero
         csr_row(CSR_CTC_MODE,     16'd1),
         csr_row(CSR_CLOCK_ENABLE, 16'd1),
         csr_row(CSR_COMPARE_A,    16'd5),
         csr_row(CSR_COMPARE_B,    16'd0),
         csr_row(CSR_PIN_A_ACTION, 16'(ACT_CLEAR)),
         csr_row(CSR_PIN_B_ACTION, 16'(ACT_TOGGLE)),
         csr_row(CSR_IRQ_ENABLE,   16'd2),
         beat_row(CMD_TICK,    3'b000),
         beat_row(CMD_TICK,    3'b000),
         beat_row(CMD_TICK,    3'b000),
         beat_row(CMD_RESTART, 3'b111),
         beat_row(CMD_CLEAR,   3'b111),
         // compare values at the top of the range
         csr_row(CSR_COMPARE_A,    16'hFFFF),
         csr_row(CSR_COMPARE_B,    16'hFFFF),
         csr_row(CSR_PIN_A_ACTION, 16'(ACT_NONE)),
         csr_row(CSR_PIN_B_ACTION, 16'(ACT_CLEAR)),
         csr_row(CSR_IRQ_ENABLE,   16'd0),
         beat_row(CMD_TICK,  3'b000),
         beat_row(CMD_TICK,  3'b000),
         beat_row(CMD_CLEAR, 3'b001),
         beat_row(CMD_CLEAR, 3'b100)
      };

      // directed table
      prev_csr = 1'b0;
      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            if (!prev_csr) settle();
            write_register(csr_index_type'(plan[i].csr_index), plan[i].csr_value);
         end else begin
            send_beat(plan[i].cmd, plan[i].mask, plan[i].known, plan[i].want);
         end
         prev_csr = plan[i].is_csr;
      end

      // random phases: new settings, then a burst of beats
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         settle();
         gaps_on = ($urandom_range(0, 4) != 0);
         for (int idx = CSR_CTC_MODE; idx <= CSR_IRQ_ENABLE; idx++) begin
            if ($urandom_range(0, 1) == 1) begin
               case (csr_index_type'(idx))
                  CSR_CTC_MODE:     value = 16'($urandom_range(0, 1));
                  CSR_CLOCK_ENABLE: value = 16'($urandom_range(0, 4) != 0);
                  CSR_COMPARE_A, CSR_COMPARE_B: begin
                     if ($urandom_range(0, 3) == 0)
                        value = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                     else
                        value = 16'($urandom_range(0, 12));
                  end
                  CSR_PIN_A_ACTION, CSR_PIN_B_ACTION: value = 16'($urandom_range(0, 3));
                  default:          value = 16'($urandom_range(0, 7));
               endcase
               write_register(csr_index_type'(idx), value);
            end
         end
         phase_len = $urandom_range(8, 60);
         repeat (phase_len) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)      cmd = CMD_TICK;
            else if (pick < 75) cmd = CMD_CLEAR;
            else if (pick < 90) cmd = CMD_RESTART;
            else                cmd = CMD_SPARE;
            send_beat(cmd, FLAG_W'($urandom_range(0, 7)), 1'b0, '0);
            random_items++;
         end
      end

      // drain
      req_tvalid <= 1'b0;
      drain = 0;
      while (timer_expected.size() != 0 && drain < 1000) begin
         @(posedge clock);
         drain++;
      end
      repeat (LATENCY + 4) @(posedge clock);
      if (timer_expected.size() != 0) begin
         $error("%0d expected results never arrived", timer_expected.size());
         mismatch_count++;
      end

      if (mismatch_count == 0)
         $display("[timer_counter_normal_ctc_compare] OK");
      else
         $display("[timer_counter_normal_ctc_compare] ERROR");
      $finish;
   end

endmodule
